[rtl/core/umcd_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// umcd_pkg
// Shared types and constants of the UART motor command decoder.
// -----------------------------------------------------------------------------
package umcd_pkg;

  // ASCII characters of the command protocol
  localparam logic [7:0] CharA = 8'h41;
  localparam logic [7:0] CharG = 8'h47;
  localparam logic [7:0] CharZ = 8'h5A;
  localparam logic [7:0] Char0 = 8'h30;

  // Percent ceiling of a decoded value
  localparam logic [7:0] PctMax = 8'd100;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift for all x below 2^15
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int unsigned Recip100Shift = 19;

  // Register reset values
  localparam logic [7:0] FwdFloorRst  = 8'd60;
  localparam logic [7:0] FwdSpanRst   = 8'd195;
  localparam logic [7:0] RevTopRst    = 8'd200;
  localparam logic [7:0] ServoFloorRst = 8'd16;
  localparam logic [7:0] ServoSpanRst = 8'd27;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FWD_FLOOR   = 3'd0,
    REG_FWD_SPAN    = 3'd1,
    REG_REV_TOP     = 3'd2,
    REG_SERVO_FLOOR = 3'd3,
    REG_SERVO_SPAN  = 3'd4
  } reg_idx_e;

  // Command codes (letter minus 'A')
  typedef enum logic [2:0] {
    CMD_LEFT_FWD  = 3'd0,
    CMD_LEFT_REV  = 3'd1,
    CMD_RIGHT_FWD = 3'd2,
    CMD_RIGHT_REV = 3'd3,
    CMD_CAM_PAN   = 3'd4,
    CMD_CAM_TILT  = 3'd5,
    CMD_BEEP      = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_code_e;

  // Output channel numbers
  typedef enum logic [2:0] {
    CH_LEFT  = 3'd0,
    CH_RIGHT = 3'd1,
    CH_PAN   = 3'd2,
    CH_TILT  = 3'd3,
    CH_BEEP  = 3'd4
  } chan_e;

  // Closed frame handed from front to back
  typedef struct packed {
    cmd_code_e  code;
    logic [6:0] pct;
    logic       clamp;
  } cmd_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0] fwd_floor;
    logic [7:0] fwd_span;
    logic [7:0] rev_top;
    logic [7:0] servo_floor;
    logic [7:0] servo_span;
  } cfg_t;

endpackage

[rtl/core/umcd_front.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// umcd_front
// Frame parser: tracks the open command, folds digits into the value and
// pushes one clamped command item when the terminator arrives.
// -----------------------------------------------------------------------------
module umcd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output umcd_pkg::cmd_t   push_data_o
);

  umcd_pkg::cmd_code_e code_q, code_d;
  logic [7:0]          acc_q, acc_d;
  logic                open_q, open_d;
  logic                accept;
  logic                is_letter;
  logic                is_term;
  logic                clamp;

  assign rx_ready_o = ~q_full_i;
  assign accept     = rx_valid_i & rx_ready_o;
  assign is_letter  = (rx_byte_i >= umcd_pkg::CharA) && (rx_byte_i <= umcd_pkg::CharG);
  assign is_term    = (rx_byte_i == umcd_pkg::CharZ);

  // Clamp the accumulated value at 100
  assign clamp               = acc_q > umcd_pkg::PctMax;
  assign push_data_o.code    = code_q;
  assign push_data_o.clamp   = clamp;
  assign push_data_o.pct     = clamp ? umcd_pkg::PctMax[6:0] : acc_q[6:0];

  assign push_o = accept & ~is_letter & open_q & is_term;

  // Frame state update
  always_comb begin
    code_d = code_q;
    acc_d  = acc_q;
    open_d = open_q;
    if (accept) begin
      if (is_letter) begin
        code_d = umcd_pkg::cmd_code_e'(3'(rx_byte_i - umcd_pkg::CharA));
        acc_d  = '0;
        open_d = 1'b1;
      end else if (open_q) begin
        if (is_term) begin
          open_d = 1'b0;
        end else begin
          // acc * 10 + byte - '0', modulo 256
          acc_d = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + rx_byte_i - umcd_pkg::Char0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= umcd_pkg::CMD_NONE;
      acc_q  <= '0;
      open_q <= 1'b0;
    end else begin
      code_q <= code_d;
      acc_q  <= acc_d;
      open_q <= open_d;
    end
  end

endmodule

[rtl/core/umcd_queue.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// umcd_queue
// Two-entry command queue between the frame parser and the duty pipeline.
// -----------------------------------------------------------------------------
module umcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  umcd_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output umcd_pkg::cmd_t pop_data_o
);

  umcd_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/umcd_back.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// umcd_back
// Duty pipeline: percent times span or top, reciprocal divide by 100, then
// saturating offset or top minus quotient, mapped into the output register.
// -----------------------------------------------------------------------------
module umcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  umcd_pkg::cfg_t cfg_i,
  input  logic           q_empty_i,
  input  umcd_pkg::cmd_t q_data_i,
  output logic           pop_o,
  output logic [2:0]     channel_o,
  output logic [7:0]     duty_o,
  output logic           direction_pin_o,
  output logic           enable_o,
  output logic           clamped_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);

  // Stage 1: product
  logic           v1_q;
  umcd_pkg::cmd_t c1_q;
  logic [14:0]    prod1_q;
  // Stage 2: quotient
  logic           v2_q;
  umcd_pkg::cmd_t c2_q;
  logic [7:0]     quot2_q;
  // Stage 3: output register
  logic           v3_q;
  logic [2:0]     chan_q, chan_d;
  logic [7:0]     duty_q, duty_d;
  logic           dir_q, dir_d;
  logic           en_q, en_d;
  logic           clamp_q;

  logic           adv1, adv2, adv3;
  logic [7:0]     factor;
  logic [27:0]    recip_prod;
  logic [8:0]     up_sum;
  logic [7:0]     up_base;
  logic [7:0]     up_sat;
  logic           pct_nz;

  // Stage enables: a stage loads when it is empty or its item moves on
  assign adv3  = ~v3_q | out_ready_i;
  assign adv2  = ~v2_q | adv3;
  assign adv1  = ~v1_q | adv2;
  assign pop_o = adv1 & ~q_empty_i;

  // Multiplier operand per command
  always_comb begin
    unique case (q_data_i.code)
      umcd_pkg::CMD_LEFT_FWD, umcd_pkg::CMD_RIGHT_REV: factor = cfg_i.fwd_span;
      umcd_pkg::CMD_LEFT_REV, umcd_pkg::CMD_RIGHT_FWD: factor = cfg_i.rev_top;
      umcd_pkg::CMD_CAM_PAN, umcd_pkg::CMD_CAM_TILT:   factor = cfg_i.servo_span;
      default:                                         factor = '0;
    endcase
  end

  assign recip_prod = {13'b0, prod1_q} * {15'b0, umcd_pkg::Recip100};

  // Final duty and pin levels
  always_comb begin
    up_base = (c2_q.code == umcd_pkg::CMD_CAM_PAN || c2_q.code == umcd_pkg::CMD_CAM_TILT) ?
              cfg_i.servo_floor : cfg_i.fwd_floor;
    up_sum  = {1'b0, up_base} + {1'b0, quot2_q};
    up_sat  = up_sum[8] ? 8'hFF : up_sum[7:0];
    pct_nz  = c2_q.pct != '0;
    chan_d  = umcd_pkg::CH_BEEP;
    duty_d  = '0;
    dir_d   = 1'b0;
    en_d    = 1'b0;
    unique case (c2_q.code)
      umcd_pkg::CMD_LEFT_FWD: begin
        chan_d = umcd_pkg::CH_LEFT;
        duty_d = up_sat;
        dir_d  = 1'b1;
        en_d   = pct_nz;
      end
      umcd_pkg::CMD_LEFT_REV: begin
        chan_d = umcd_pkg::CH_LEFT;
        duty_d = cfg_i.rev_top - quot2_q;
        en_d   = pct_nz;
      end
      umcd_pkg::CMD_RIGHT_FWD: begin
        chan_d = umcd_pkg::CH_RIGHT;
        duty_d = cfg_i.rev_top - quot2_q;
        en_d   = pct_nz;
      end
      umcd_pkg::CMD_RIGHT_REV: begin
        chan_d = umcd_pkg::CH_RIGHT;
        duty_d = up_sat;
        dir_d  = 1'b1;
        en_d   = pct_nz;
      end
      umcd_pkg::CMD_CAM_PAN: begin
        chan_d = umcd_pkg::CH_PAN;
        duty_d = up_sat;
      end
      umcd_pkg::CMD_CAM_TILT: begin
        chan_d = umcd_pkg::CH_TILT;
        duty_d = up_sat;
      end
      default: begin
        chan_d = umcd_pkg::CH_BEEP;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= ~q_empty_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      c1_q    <= q_data_i;
      prod1_q <= {8'b0, q_data_i.pct} * {7'b0, factor};
    end
    if (adv2) begin
      c2_q    <= c1_q;
      quot2_q <= recip_prod[umcd_pkg::Recip100Shift +: 8];
    end
    if (adv3) begin
      chan_q  <= chan_d;
      duty_q  <= duty_d;
      dir_q   <= dir_d;
      en_q    <= en_d;
      clamp_q <= c2_q.clamp;
    end
  end

  assign out_valid_o     = v3_q;
  assign channel_o       = chan_q;
  assign duty_o          = duty_q;
  assign direction_pin_o = dir_q;
  assign enable_o        = en_q;
  assign clamped_o       = clamp_q;

endmodule

[rtl/core/uart_motor_command_decoder.sv]
`timescale 1ns / 1ps
// Path: once its terminating 'Z' byte is accepted, a result passes through the
//   queue entry, product stage, quotient stage and output register, in order.
// Throughput: one byte per cycle; the duty pipeline takes one command per cycle unless out_ready_i holds it back.
// The input stalls only while the two-entry command queue is full.
// Reset: frame closed, no command, value zero, registers at their defaults.
// -----------------------------------------------------------------------------
// uart_motor_command_decoder
// Decodes framed UART motor commands into channel duty results; holds the
// configuration registers and joins the frame parser, queue and duty pipeline.
// -----------------------------------------------------------------------------
module uart_motor_command_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  output logic [2:0] channel_o,
  output logic [7:0] duty_o,
  output logic       direction_pin_o,
  output logic       enable_o,
  output logic       clamped_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  umcd_pkg::cfg_t cfg_q, cfg_d;
  umcd_pkg::cmd_t push_data;
  umcd_pkg::cmd_t pop_data;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Configuration register writes; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        umcd_pkg::REG_FWD_FLOOR:   cfg_d.fwd_floor   = cfg_wdata_i;
        umcd_pkg::REG_FWD_SPAN:    cfg_d.fwd_span    = cfg_wdata_i;
        umcd_pkg::REG_REV_TOP:     cfg_d.rev_top     = cfg_wdata_i;
        umcd_pkg::REG_SERVO_FLOOR: cfg_d.servo_floor = cfg_wdata_i;
        umcd_pkg::REG_SERVO_SPAN:  cfg_d.servo_span  = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_floor   <= umcd_pkg::FwdFloorRst;
      cfg_q.fwd_span    <= umcd_pkg::FwdSpanRst;
      cfg_q.rev_top     <= umcd_pkg::RevTopRst;
      cfg_q.servo_floor <= umcd_pkg::ServoFloorRst;
      cfg_q.servo_span  <= umcd_pkg::ServoSpanRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  umcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  umcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  umcd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_data_i        (pop_data),
    .pop_o           (pop),
    .channel_o       (channel_o),
    .duty_o          (duty_o),
    .direction_pin_o (direction_pin_o),
    .enable_o        (enable_o),
    .clamped_o       (clamped_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule
